@@ rtl/oaht_pkg.sv @@
// Shared constants, codes and types of the open-address hash table.
// Has no dependencies. Every other file in the table imports it.
`timescale 1ns / 1ps

package oaht_pkg;

	// Table geometry (SLOTS must be a power of two)
	localparam int SLOTS      = 64;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int PROBE_W    = $clog2(SLOTS + 1);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int VALUE_BITS = 64;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int KEY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;
	localparam int CMP_W    = ((CNT_W > FILL_W) ? CNT_W : FILL_W) + 1;

	localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(44);

	// Request modes
	localparam logic [MODE_W-1:0] MODE_GET  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEL  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	// Response status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// Slot memory read request
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} slot_rd_req_t;

	// Slot memory read data; an entry never written reads as empty
	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic                  tomb;
		logic [VALUE_BITS-1:0] val;
	} slot_rd_t;

	// Slot memory write request
	typedef struct packed {
		logic                  wr_key;
		logic                  wr_val;
		logic [IDX_W-1:0]      addr;
		logic [KEY_W-1:0]      key;
		logic                  tomb;
		logic [VALUE_BITS-1:0] val;
	} slot_wr_t;

endpackage

@@ rtl/oaht_if.sv @@
// Valid/ready channel interfaces of the hash table: request, response, config.
// Depends on oaht_pkg for field widths.
`timescale 1ns / 1ps

interface oaht_req_if;
	import oaht_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key_id;
	logic [HASH_W-1:0] key_hash;
	logic [VAL_W-1:0]  new_value;
	modport source (output valid, mode, key_id, key_hash, new_value, input ready);
	modport sink   (input valid, mode, key_id, key_hash, new_value, output ready);
endinterface

interface oaht_rsp_if;
	import oaht_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                was_new;
	logic [VAL_W-1:0]    found_value;
	modport source (output valid, status, was_new, found_value, input ready);
	modport sink   (input valid, status, was_new, found_value, output ready);
endinterface

interface oaht_cfg_if;
	import oaht_pkg::*;
	logic              valid;
	logic              ready;
	logic [FILL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ rtl/oaht_slot_mem.sv @@
// Slot storage: key/tombstone memory, value memory and per-slot written bits.
// Depends on oaht_pkg. One read and one write port, read data registered.
`timescale 1ns / 1ps

module oaht_slot_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oaht_pkg::slot_rd_req_t rd_req,
	input  oaht_pkg::slot_wr_t    wr,
	output oaht_pkg::slot_rd_t    rd
);
	import oaht_pkg::*;

	logic [KEY_W:0]         key_mem [SLOTS];
	logic [VALUE_BITS-1:0]  val_mem [SLOTS];
	logic [SLOTS-1:0]       written_q;

	logic [KEY_W:0]         key_rd_q;
	logic [VALUE_BITS-1:0]  val_rd_q;
	logic                   written_rd_q;

	// Write key and tombstone, and value, at the write address, each under its own enable
	always_ff @(posedge clk) begin
		if (wr.wr_key) begin
			key_mem[wr.addr] <= {wr.tomb, wr.key};
		end
		if (wr.wr_val) begin
			val_mem[wr.addr] <= wr.val;
		end
	end

	// Track slots written since reset; others read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr.wr_key) begin
			written_q[wr.addr] <= 1'b1;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			key_rd_q     <= key_mem[rd_req.addr];
			val_rd_q     <= val_mem[rd_req.addr];
			written_rd_q <= written_q[rd_req.addr];
		end
	end

	// Mask entries that were never written
	assign rd.key  = written_rd_q ? key_rd_q[KEY_W-1:0] : '0;
	assign rd.tomb = written_rd_q ? key_rd_q[KEY_W] : 1'b0;
	assign rd.val  = val_rd_q;

endmodule

@@ rtl/open_address_hash_table_core.sv @@
// Open-address hash table with tombstones over 64 slots; depends on oaht_pkg, the
// channel interfaces and oaht_slot_mem (one read and one write port).
// Each request walks P slots (1..SLOTS), one probe per cycle on the memory read port;
// a request with key zero or mode three skips the walk and goes straight to the response.
// The next request is taken while the previous response waits in the output register.
// Reset clears all slots at once through per-slot written bits; fill limit resets to 44.
`timescale 1ns / 1ps

module open_address_hash_table_core (
	input  logic       clk,
	input  logic       arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp,
	oaht_cfg_if.sink   cfg
);
	import oaht_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PROBE = 2'd1;
	localparam logic [1:0] S_RESP  = 2'd2;

	logic [1:0]            state_q;
	logic [FILL_W-1:0]     fill_q;
	logic [CNT_W-1:0]      used_q;

	// Request held during the probe walk
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_W-1:0]      key_q;
	logic [HASH_W-1:0]     hash_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [IDX_W-1:0]      idx_q;
	logic [PROBE_W-1:0]    cnt_q;
	logic                  have_tomb_q;
	logic [IDX_W-1:0]      first_tomb_q;

	// Finished result, and the output register
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_new_q;
	logic [VAL_W-1:0]      res_val_q;
	logic                  out_vld_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_new_q;
	logic [VAL_W-1:0]      out_val_q;

	slot_rd_req_t          rd_req;
	slot_rd_t              rd;
	slot_wr_t              wr;

	logic                  req_fire;
	logic                  bad_req;
	logic [IDX_W-1:0]      init_idx;
	logic [IDX_W-1:0]      next_idx;
	logic [PROBE_W-1:0]    step_j;
	logic [2*PROBE_W-1:0]  step_sq;
	logic [HASH_W-1:0]     step_sum;

	logic                  slot_free;
	logic                  slot_tomb;
	logic                  slot_match;
	logic                  last_probe;
	logic                  probe_done;
	logic                  tomb_any;
	logic [IDX_W-1:0]      tomb_slot;
	logic                  room;

	logic [STATUS_W-1:0]   nxt_status;
	logic                  nxt_new;
	logic [VAL_W-1:0]      nxt_val;
	logic                  bump_used;

	oaht_slot_mem u_slot_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (rd_req),
		.wr     (wr),
		.rd     (rd)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign bad_req   = (req.key_id == '0) || (req.mode == MODE_NONE);
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.was_new     = out_new_q;
	assign rsp.found_value = out_val_q;

	// Probe addresses: first (hash+1), then hash + j*j + index, all mod 2^32
	assign init_idx = IDX_W'((req.key_hash + HASH_W'(1)) % SLOTS);
	assign step_j   = cnt_q + PROBE_W'(1);
	assign step_sq  = step_j * step_j;
	assign step_sum = hash_q + HASH_W'(step_sq) + HASH_W'(idx_q);
	assign next_idx = IDX_W'(step_sum % SLOTS);

	// Classify the slot just read
	assign slot_free  = (rd.key == '0) && !rd.tomb;
	assign slot_tomb  = (rd.key == '0) && rd.tomb;
	assign slot_match = (rd.key != '0) && (rd.key == key_q);
	assign last_probe = (cnt_q == PROBE_W'(SLOTS));
	assign probe_done = slot_free || slot_match || last_probe;
	assign tomb_any   = have_tomb_q || slot_tomb;
	assign tomb_slot  = have_tomb_q ? first_tomb_q : idx_q;
	assign room       = (CMP_W'(used_q) + CMP_W'(1)) <= CMP_W'(fill_q);

	// Issue a read at request accept and at each further probe
	always_comb begin
		rd_req.en   = 1'b0;
		rd_req.addr = init_idx;
		if (state_q == S_IDLE) begin
			rd_req.en = req_fire;
		end else if ((state_q == S_PROBE) && !probe_done) begin
			rd_req.en   = 1'b1;
			rd_req.addr = next_idx;
		end
	end

	// Decide the outcome and the slot update when the walk ends
	always_comb begin
		wr         = '0;
		wr.addr    = idx_q;
		wr.key     = key_q;
		wr.val     = val_q;
		nxt_status = STAT_MISS;
		nxt_new    = 1'b0;
		nxt_val    = '0;
		bump_used  = 1'b0;
		if (slot_match) begin
			nxt_status = STAT_OK;
			unique case (mode_q)
				MODE_GET: begin
					nxt_val = VAL_W'(rd.val);
				end
				MODE_DEL: begin
					wr.wr_key = 1'b1;
					wr.key    = '0;
					wr.tomb   = 1'b1;
				end
				default: begin
					wr.wr_val = 1'b1;
				end
			endcase
		end else if (mode_q == MODE_ADD) begin
			if (tomb_any) begin
				wr.wr_key  = 1'b1;
				wr.wr_val  = 1'b1;
				wr.addr    = tomb_slot;
				nxt_status = STAT_OK;
				nxt_new    = 1'b1;
			end else if (slot_free && room) begin
				wr.wr_key  = 1'b1;
				wr.wr_val  = 1'b1;
				bump_used  = 1'b1;
				nxt_status = STAT_OK;
				nxt_new    = 1'b1;
			end else begin
				nxt_status = STAT_FULL;
			end
		end
		// Write only on the cycle the walk ends
		if (!((state_q == S_PROBE) && probe_done)) begin
			wr.wr_key = 1'b0;
			wr.wr_val = 1'b0;
		end
	end

	// Fill limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			fill_q <= cfg.data;
		end
	end

	// Control: sequencer, used count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// Raise valid when a result moves out, drop it once taken
			if ((state_q == S_RESP) && (!out_vld_q || rsp.ready)) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= bad_req ? S_RESP : S_PROBE;
					end
				end
				S_PROBE: begin
					if (probe_done) begin
						state_q <= S_RESP;
						if (bump_used) begin
							used_q <= used_q + CNT_W'(1);
						end
					end
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: hold the request, advance the walk, stage the result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q       <= req.mode;
			key_q        <= req.key_id;
			hash_q       <= req.key_hash;
			val_q        <= req.new_value[VALUE_BITS-1:0];
			idx_q        <= init_idx;
			cnt_q        <= PROBE_W'(1);
			have_tomb_q  <= 1'b0;
			res_status_q <= STAT_MISS;
			res_new_q    <= 1'b0;
			res_val_q    <= '0;
		end
		if (state_q == S_PROBE) begin
			if (probe_done) begin
				res_status_q <= nxt_status;
				res_new_q    <= nxt_new;
				res_val_q    <= nxt_val;
			end else begin
				idx_q <= next_idx;
				cnt_q <= step_j;
				if (slot_tomb && !have_tomb_q) begin
					have_tomb_q  <= 1'b1;
					first_tomb_q <= idx_q;
				end
			end
		end
		if ((state_q == S_RESP) && (!out_vld_q || rsp.ready)) begin
			out_status_q <= res_status_q;
			out_new_q    <= res_new_q;
			out_val_q    <= res_val_q;
		end
	end

endmodule

@@ rtl/oaht_chk.sv @@
// Port-level checks of the hash table core, attached by bind.
// Depends on oaht_pkg and open_address_hash_table_core.
`timescale 1ns / 1ps

module oaht_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [oaht_pkg::STATUS_W-1:0] rsp_status,
	input logic                          rsp_was_new,
	input logic [oaht_pkg::VAL_W-1:0]    rsp_found_value
);
	import oaht_pkg::*;

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_was_new) && $stable(rsp_found_value))
		else $error("stalled response changed");

	// One request in flight: no accept right after an accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// A new key is only reported on success
	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_was_new |-> rsp_status == STAT_OK)
		else $error("was_new set on a failed request");

	// A nonzero value is only returned by a successful lookup
	a_val_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_found_value != '0) |-> rsp_status == STAT_OK && !rsp_was_new)
		else $error("value returned without a hit");

	// Status is one of the three defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_MISS
			|| rsp_status == STAT_FULL)
		else $error("undefined status code");

endmodule

bind open_address_hash_table_core oaht_chk u_oaht_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_was_new     (rsp.was_new),
	.rsp_found_value (rsp.found_value)
);

@@ bench/open_address_hash_table_core_test.sv @@
// Self-checking bench for the open-address hash table: drives get, add and delete
// requests, predicts every response with its own table model and compares them.
// Depends on oaht_pkg, the channel interfaces and open_address_hash_table_core.
`timescale 1ns / 1ps

module open_address_hash_table_core_test;
	import oaht_pkg::*;

	localparam int POOL_SIZE  = 80;
	localparam int CALM_DEPTH = 150;
	localparam int LONG_HOLD  = 240;

	typedef enum logic [1:0] {ENT_REQ, ENT_CFG, ENT_DRAIN} ent_kind_e;

	typedef struct packed {
		ent_kind_e         kind;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  val;
		logic [FILL_W-1:0] limit;
	} table_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                was_new;
		logic [VAL_W-1:0]    found;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	oaht_req_if req_ch ();
	oaht_rsp_if rsp_ch ();
	oaht_cfg_if cfg_ch ();

	open_address_hash_table_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Table model state
	logic [KEY_W-1:0]  tbl_key [SLOTS];
	logic [VAL_W-1:0]  tbl_val [SLOTS];
	bit                tbl_tomb [SLOTS];
	int                tbl_used;
	logic [FILL_W-1:0] tbl_limit;

	table_op_t op_backlog [$];
	outcome_t  answers_due [$];

	logic [KEY_W-1:0]  pool_key [POOL_SIZE];
	logic [HASH_W-1:0] pool_hash [POOL_SIZE];

	// Driver state
	table_op_t cur_op;
	table_op_t nxt_op;
	bit        hold_req, hold_cfg, send_req, send_cfg;
	int        src_gap, src_mood, src_cyc;
	int        req_taken;
	logic      calm;

	// Monitor state
	outcome_t  want;
	int        rsp_seen, got;
	int        snk_gap, snk_mood, snk_cyc, long_hold;

	int n_err, n_ok, n_miss, n_full, n_new, n_limits;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the table model and return the expected response
	function automatic outcome_t table_apply(table_op_t op);
		outcome_t          o;
		int                idx, tomb_idx;
		bit                have_tomb, matched, hit_empty;
		logic [HASH_W-1:0] sum;
		o.status  = STAT_MISS;
		o.was_new = 1'b0;
		o.found   = '0;
		tomb_idx  = 0;
		have_tomb = 1'b0;
		matched   = 1'b0;
		hit_empty = 1'b0;
		if (op.key == '0 || op.mode == MODE_NONE)
			return o;
		// walk the quadratic probe chain; slot count is a power of two
		sum = op.hash + 32'd1;
		idx = int'(sum[IDX_W-1:0]);
		for (int i = 1; i <= SLOTS; i++) begin
			if (tbl_key[idx] == '0) begin
				if (!tbl_tomb[idx]) begin
					hit_empty = 1'b1;
					break;
				end
				if (!have_tomb) begin
					have_tomb = 1'b1;
					tomb_idx  = idx;
				end
			end else if (tbl_key[idx] == op.key) begin
				matched = 1'b1;
				break;
			end
			sum = op.hash + 32'((i + 1) * (i + 1)) + 32'(idx);
			idx = int'(sum[IDX_W-1:0]);
		end
		case (op.mode)
			MODE_GET: begin
				if (matched) begin
					o.status = STAT_OK;
					o.found  = tbl_val[idx];
				end
			end
			MODE_DEL: begin
				if (matched) begin
					tbl_key[idx]  = '0;
					tbl_tomb[idx] = 1'b1;
					o.status      = STAT_OK;
				end
			end
			default: begin
				if (matched) begin
					tbl_val[idx] = op.val;
					o.status     = STAT_OK;
				end else if (have_tomb) begin
					// reuse the first tombstone passed, whatever the fill limit
					tbl_key[tomb_idx]  = op.key;
					tbl_val[tomb_idx]  = op.val;
					tbl_tomb[tomb_idx] = 1'b0;
					o.status           = STAT_OK;
					o.was_new          = 1'b1;
				end else if (hit_empty && tbl_used + 1 <= int'(tbl_limit)) begin
					tbl_key[idx]  = op.key;
					tbl_val[idx]  = op.val;
					tbl_tomb[idx] = 1'b0;
					tbl_used++;
					o.status      = STAT_OK;
					o.was_new     = 1'b1;
				end else begin
					o.status = STAT_FULL;
				end
			end
		endcase
		return o;
	endfunction

	task automatic push_op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
			logic [VAL_W-1:0] v);
		table_op_t op;
		op       = '0;
		op.kind  = ENT_REQ;
		op.mode  = m;
		op.key   = k;
		op.hash  = h;
		op.val   = v;
		op_backlog.push_back(op);
	endtask

	task automatic push_limit(logic [FILL_W-1:0] lim);
		table_op_t op;
		op       = '0;
		op.kind  = ENT_CFG;
		op.limit = lim;
		op_backlog.push_back(op);
	endtask

	// Mostly pool keys with stable hashes, some noise keys and rehashed pool keys
	task automatic add_random(int count);
		logic [MODE_W-1:0] m;
		logic [KEY_W-1:0]  k;
		logic [HASH_W-1:0] h;
		logic [VAL_W-1:0]  v;
		int                pick, r;
		for (int n = 0; n < count; n++) begin
			v    = {$urandom, $urandom};
			pick = $urandom_range(0, POOL_SIZE - 1);
			r    = $urandom_range(0, 99);
			if (r < 85) begin
				k = pool_key[pick];
				h = pool_hash[pick];
				r = $urandom_range(0, 99);
				m = (r < 40) ? MODE_ADD : (r < 72) ? MODE_GET : (r < 97) ? MODE_DEL : MODE_NONE;
			end else begin
				k = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
				if (r < 90)
					k = pool_key[pick];
				h = $urandom;
				m = MODE_W'($urandom_range(0, 3));
			end
			push_op(m, k, h, v);
		end
	endtask

	task automatic check_field(string what, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
		if (exp_v !== act_v) begin
			n_err++;
			if (n_err <= 10)
				$display("mismatch in %s of response %0d: expected %h, got %h",
					what, rsp_seen + 1, exp_v, act_v);
		end
	endtask

	// Request and config driver, fed from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.mode      <= MODE_GET;
			req_ch.key_id    <= '0;
			req_ch.key_hash  <= '0;
			req_ch.new_value <= '0;
			cfg_ch.valid     <= 1'b0;
			cfg_ch.data      <= '0;
			req_taken        <= 0;
			calm             <= 1'b0;
			src_gap  = 0;
			src_mood = 0;
			src_cyc  = 0;
			tbl_used = 0;
			tbl_limit = FILL_RESET;
			for (int s = 0; s < SLOTS; s++) begin
				tbl_key[s]  = '0;
				tbl_val[s]  = '0;
				tbl_tomb[s] = 1'b0;
			end
		end else begin
			hold_req = req_ch.valid && !req_ch.ready;
			hold_cfg = cfg_ch.valid && !cfg_ch.ready;
			send_req = 1'b0;
			send_cfg = 1'b0;
			// predict the request taken at this edge
			if (req_ch.valid && req_ch.ready) begin
				answers_due.push_back(table_apply(cur_op));
				req_taken <= req_taken + 1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				tbl_limit = cfg_ch.data;
				n_limits++;
			end
			src_cyc++;
			if (src_cyc % 256 == 0)
				src_mood = $urandom_range(0, 3);
			// pick the next request, or wait for the table to drain
			if (!hold_req && !hold_cfg && op_backlog.size() != 0) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (op_backlog[0].kind == ENT_REQ) begin
					if (!calm && src_mood != 0 && $urandom_range(0, 2 << src_mood) == 0) begin
						src_gap = $urandom_range(0, 11);
					end else begin
						cur_op   = op_backlog.pop_front();
						send_req = 1'b1;
					end
				end else if (!req_ch.valid && !cfg_ch.valid && req_taken == rsp_seen) begin
					nxt_op   = op_backlog.pop_front();
					send_cfg = (nxt_op.kind == ENT_CFG);
				end
			end
			if (!hold_req) begin
				req_ch.valid <= send_req;
				if (send_req) begin
					req_ch.mode      <= cur_op.mode;
					req_ch.key_id    <= cur_op.key;
					req_ch.key_hash  <= cur_op.hash;
					req_ch.new_value <= cur_op.val;
				end
			end
			if (!hold_cfg) begin
				cfg_ch.valid <= send_cfg;
				if (send_cfg)
					cfg_ch.data <= nxt_op.limit;
			end
			calm <= (op_backlog.size() < CALM_DEPTH);
		end
	end

	// Response monitor and ready generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_seen     <= 0;
			snk_gap   = 0;
			snk_mood  = 0;
			snk_cyc   = 0;
			long_hold = 0;
		end else begin
			got = rsp_seen;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = got + 1;
				if (answers_due.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("response %0d arrived with no request outstanding", got);
				end else begin
					want = answers_due.pop_front();
					check_field("status", VAL_W'(want.status), VAL_W'(rsp_ch.status));
					check_field("was_new", VAL_W'(want.was_new), VAL_W'(rsp_ch.was_new));
					check_field("found_value", want.found, rsp_ch.found_value);
					case (want.status)
						STAT_OK:   n_ok++;
						STAT_MISS: n_miss++;
						default:   n_full++;
					endcase
					if (want.was_new)
						n_new++;
				end
			end
			rsp_seen <= got;
			snk_cyc++;
			if (snk_cyc % 256 == 0)
				snk_mood = $urandom_range(0, 3);
			// back up the table with a long stall twice during the run
			if (rsp_ch.valid && rsp_ch.ready && (got == 300 || got == 1200))
				long_hold = LONG_HOLD;
			if (long_hold != 0) begin
				long_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && snk_mood != 0 && $urandom_range(0, 2 << snk_mood) == 0) begin
				snk_gap = $urandom_range(0, 11);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;

		// Key pool: half the hashes crowd into a few home slots
		for (int p = 0; p < POOL_SIZE; p++) begin
			do pool_key[p] = $urandom; while (pool_key[p] == '0);
			pool_hash[p] = $urandom;
			if (p < POOL_SIZE / 2)
				pool_hash[p][IDX_W-1:0] = IDX_W'($urandom_range(0, 7));
		end
		pool_key[0] = 32'h0000_0001;
		pool_key[1] = 32'hFFFF_FFFF;

		// Zero fill limit: fresh adds refused; key zero and mode three ignored
		push_limit(FILL_W'(0));
		push_op(MODE_ADD, 32'h1234_5678, 32'h0000_0003, '1);
		push_op(MODE_GET, '0, 32'h0000_0003, '0);
		push_op(MODE_ADD, '0, 32'h0000_0003, '1);
		push_op(MODE_DEL, '0, 32'h0000_0003, '0);
		push_op(MODE_NONE, 32'h1234_5678, 32'h0000_0003, '1);
		// Limit of one: add, refuse, update, delete, then reuse the tombstone
		push_limit(FILL_W'(1));
		push_op(MODE_ADD, 32'h1234_5678, 32'h0000_0003, '1);
		push_op(MODE_ADD, 32'h9ABC_DEF0, 32'h0000_0003, 64'h0123_4567_89AB_CDEF);
		push_op(MODE_ADD, 32'h1234_5678, 32'h0000_0003, '0);
		push_op(MODE_GET, 32'h1234_5678, 32'h0000_0003, '1);
		push_op(MODE_DEL, 32'h1234_5678, 32'h0000_0003, '0);
		push_op(MODE_GET, 32'h1234_5678, 32'h0000_0003, '0);
		push_op(MODE_DEL, 32'h1234_5678, 32'h0000_0003, '0);
		push_op(MODE_ADD, 32'h9ABC_DEF0, 32'h0000_0003, 64'h5555_AAAA_5555_AAAA);
		push_op(MODE_GET, 32'h9ABC_DEF0, 32'h0000_0003, '0);
		// Largest limit: field extremes and a collision on a taken home slot
		push_limit(FILL_W'(127));
		push_op(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		push_op(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		push_op(MODE_ADD, 32'h0000_0001, 32'h0000_0000, '0);
		push_op(MODE_GET, 32'h0000_0001, 32'h0000_0000, '1);
		push_op(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		push_op(MODE_DEL, 32'h0F0F_0F0F, 32'h0000_0000, '0);
		push_op(MODE_ADD, 32'h1234_5678, 32'h0000_0043, 64'hAAAA_5555_AAAA_5555);
		push_op(MODE_GET, 32'h1234_5678, 32'h0000_0043, '0);

		// Random phases over several limits, with one full drain in the middle
		push_limit(FILL_RESET);
		add_random(300);
		op_backlog.push_back('{kind: ENT_DRAIN, default: '0});
		add_random(300);
		push_limit(FILL_W'(20));
		add_random(200);
		push_limit(FILL_W'(127));
		add_random(450);
		push_limit(FILL_W'(SLOTS));
		add_random(450);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (op_backlog.size() != 0 || req_ch.valid || cfg_ch.valid || answers_due.size() != 0);
		repeat (SLOTS + 16) @(posedge clk);

		$display("Covered %0d requests under %0d fill limits: %0d done, %0d not found, %0d full",
			rsp_seen, n_limits, n_ok, n_miss, n_full);
		$display("%0d keys were newly placed; %0d mismatches were counted", n_new, n_err);
		if (n_err == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
